// File: rtl/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length encoder.
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

    // Longest run that one packet can describe, as repeat count minus one.
    localparam int unsigned MAX_REPEAT  = 127;
    localparam int unsigned COUNT_W     = 7;
    localparam logic [7:0]  HEADER_BASE = 8'h80;

    // Command queue geometry between the front and the back.
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

    // One incoming pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       final_pixel;
    } pixel_t;

    // One outgoing run packet.
    typedef struct packed {
        logic [7:0] packet_header;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       image_done;
    } packet_t;

    // Color of the open run.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // Work for the back: a closed run, a flushed run, or both in that order.
    typedef struct packed {
        logic    has_close;
        packet_t close_pkt;
        logic    has_flush;
        packet_t flush_pkt;
    } rle_cmd_t;

    // Queue occupancy status seen by the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // Build a run packet from a color and a repeat count.
    function automatic packet_t make_packet(color_t c, logic [COUNT_W-1:0] cnt, logic done);
        packet_t p;
        p.packet_header = HEADER_BASE + {1'b0, cnt};
        p.out_blue      = c.blue;
        p.out_green     = c.green;
        p.out_red       = c.red;
        p.image_done    = done;
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tga_rle_front.sv
// Front of the encoder: run tracking and packet command generation.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_front (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       pixel_valid,
    output logic                      pixel_ready,
    input  tga_rle_pkg::pixel_t       pixel,
    input  tga_rle_pkg::queue_stat_t  qstat,
    output logic                      push,
    output tga_rle_pkg::rle_cmd_t     push_cmd
);
    import tga_rle_pkg::*;

    color_t               held_color_reg, held_color_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 color_valid_reg, color_valid_next;

    color_t               color;
    color_t               run_color;
    logic [COUNT_W-1:0]   run_count;
    logic                 extend;
    logic                 close_run;
    logic                 accept;

    // A transfer is taken whenever the queue has room for its command.
    assign pixel_ready = !qstat.full;
    assign accept      = pixel_valid && pixel_ready;

    assign color.red   = pixel.red;
    assign color.green = pixel.green;
    assign color.blue  = pixel.blue;

    // Classify the pixel against the open run.
    always_comb
    begin
        extend    = color_valid_reg && (color == held_color_reg)
                    && (count_reg < COUNT_W'(MAX_REPEAT));
        close_run = color_valid_reg && !extend;
        if (extend)
        begin
            run_color = held_color_reg;
            run_count = count_reg + 1'b1;
        end
        else
        begin
            run_color = color;
            run_count = '0;
        end
    end

    // Commands for the back and the next run state.
    always_comb
    begin
        push_cmd.has_close = close_run;
        push_cmd.close_pkt = make_packet(held_color_reg, count_reg, 1'b0);
        push_cmd.has_flush = pixel.final_pixel;
        push_cmd.flush_pkt = make_packet(run_color, run_count, 1'b1);
        push               = accept && (close_run || pixel.final_pixel);

        held_color_next  = held_color_reg;
        count_next       = count_reg;
        color_valid_next = color_valid_reg;
        if (accept)
        begin
            if (pixel.final_pixel)
            begin
                held_color_next  = '0;
                count_next       = '0;
                color_valid_next = 1'b0;
            end
            else
            begin
                held_color_next  = run_color;
                count_next       = run_count;
                color_valid_next = 1'b1;
            end
        end
    end

    // Run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_color_reg  <= '0;
            count_reg       <= '0;
            color_valid_reg <= 1'b0;
        end
        else
        begin
            held_color_reg  <= held_color_next;
            count_reg       <= count_next;
            color_valid_reg <= color_valid_next;
        end
    end

`ifndef SYNTHESIS
    // No run is held right after the final pixel.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pixel.final_pixel |=> !color_valid_reg && (count_reg == '0))
        else $error("run state not cleared after final pixel");

    // Count stays zero while no run is open.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !color_valid_reg |-> (count_reg == '0))
        else $error("repeat count nonzero with no run open");

    // A pixel that extends the run never produces a closing packet.
    a_extend_no_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && extend |-> !push_cmd.has_close)
        else $error("extended run also closed");
`endif

endmodule

`default_nettype wire

// File: rtl/tga_rle_queue.sv
// Small command queue between the encoder front and back.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_queue (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    input  tga_rle_pkg::rle_cmd_t     push_cmd,
    input  wire                       pop,
    output tga_rle_pkg::rle_cmd_t     head,
    output tga_rle_pkg::queue_stat_t  qstat
);
    import tga_rle_pkg::*;

    rle_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head        = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// File: rtl/tga_rle_back.sv
// Back of the encoder: sends queued packets through the output register.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  tga_rle_pkg::rle_cmd_t     head,
    input  tga_rle_pkg::queue_stat_t  qstat,
    output logic                      pop,
    output logic                      packet_valid,
    input  wire                       packet_ready,
    output tga_rle_pkg::packet_t      packet
);
    import tga_rle_pkg::*;

    logic     valid_reg, valid_next;
    logic     sent_close_reg, sent_close_next;
    packet_t  packet_reg, packet_next;
    logic     head_first;
    logic     last_of_entry;
    logic     load;

    assign packet_valid = valid_reg;
    assign packet       = packet_reg;

    // Choose the next packet of the head command.
    always_comb
    begin
        head_first    = head.has_close && !sent_close_reg;
        last_of_entry = !head_first || !head.has_flush;
        load          = !qstat.empty && (!valid_reg || packet_ready);
        pop           = load && last_of_entry;

        packet_next     = packet_reg;
        valid_next      = valid_reg && !packet_ready;
        sent_close_next = sent_close_reg;
        if (load)
        begin
            packet_next     = head_first ? head.close_pkt : head.flush_pkt;
            valid_next      = 1'b1;
            sent_close_next = !last_of_entry;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            sent_close_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            sent_close_reg <= sent_close_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        packet_reg <= packet_next;
    end

`ifndef SYNTHESIS
    // A half-sent command must stay at the head of the queue.
    a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        sent_close_reg |-> !qstat.empty && head.has_close && head.has_flush)
        else $error("partially sent command lost");

    // Every sent packet is a run packet.
    a_run_header: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> packet_reg.packet_header[7])
        else $error("packet header without run flag");

    // A closing packet is never marked as the end of the image.
    a_close_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        load && head_first |=> !packet_reg.image_done)
        else $error("closing packet marked as image end");
`endif

endmodule

`default_nettype wire

// File: rtl/tga_run_length_encoder.sv
// Top level of the TGA run-length encoder for 24-bit pixels.
`timescale 1ns / 1ps
`default_nettype none

// The encoder takes one pixel per cycle and turns it into TGA run packets
// (header 0x80 plus repeat count minus one, then blue, green, red); it never
// makes raw packets. The front compares each pixel with the open run and, in
// the same cycle, queues a command holding the closed run, the flushed final
// run, or both. A four-entry command queue separates it from the back, which
// sends one packet per cycle, when packet_ready allows, through a registered
// output; a packet passes through a queue entry and then the output register.
// A pixel that both closes a run and ends the image needs two output packets,
// so sustained input rate is one pixel per cycle except where such pixels
// come often enough to fill the queue; the single output packet per cycle is
// what bounds it. The pixel input stalls only when the command queue is full.
module tga_run_length_encoder (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   pixel_valid,
    output logic                  pixel_ready,
    input  tga_rle_pkg::pixel_t   pixel,
    output logic                  packet_valid,
    input  wire                   packet_ready,
    output tga_rle_pkg::packet_t  packet
);
    import tga_rle_pkg::*;

    logic         push;
    logic         pop;
    rle_cmd_t     push_cmd;
    rle_cmd_t     head;
    queue_stat_t  qstat;

    tga_rle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .qstat       (qstat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tga_rle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    tga_rle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .packet_valid (packet_valid),
        .packet_ready (packet_ready),
        .packet       (packet)
    );

endmodule

`default_nettype wire
